/* sv/pcp_pkg.sv */
package pcp_pkg;

    localparam int unsigned PCP_REF_HZ = 32'd50000000;

    localparam int PIX_W      = 28;
    localparam int VCO_W      = 31;
    localparam int FB_INT_W   = 6;
    localparam int FB_FULL_W  = 12;   // integer part of ratio for the smallest reference
    localparam int FRAC_W     = 24;
    localparam int PDIV_W     = 3;
    localparam int ODIV_W     = 8;
    localparam int ACH_W      = 31;
    localparam int REF_W      = 27;
    localparam int NUM_W      = 64;
    localparam int DEN_W      = 32;
    localparam int DIV_CNT_W  = 7;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 168;

    localparam logic [31:0] PIX_MIN_HZ = 32'd1000000;
    localparam logic [31:0] PIX_MAX_HZ = 32'd200000000;
    localparam logic [PIX_W-1:0] TGT_MIN_HZ = 28'd100000000;
    localparam logic [31:0] VCO_MIN_HZ = 32'd500000000;
    localparam logic [PDIV_W-1:0] POST_MAX = 3'd7;
    localparam logic [ODIV_W-1:0] DIV_MAX = 8'hff;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_DOUBLE,
        OP_DIV_CEIL,
        OP_VCO,
        OP_DIV_RATIO,
        OP_FB,
        OP_DIV_POST,
        OP_CMP,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_DIV_PLL,
        OP_PLL,
        OP_DIV_Q,
        OP_ODIV,
        OP_DIV_ACH,
        OP_ACH,
        OP_OUT
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DOUBLE,
        S_DIV_CEIL,
        S_W_CEIL,
        S_DIV_RATIO,
        S_W_RATIO,
        S_DIV_POST,
        S_W_POST,
        S_MUL_LO,
        S_MUL_HI,
        S_DIV_PLL,
        S_W_PLL,
        S_DIV_Q,
        S_W_Q,
        S_DIV_ACH,
        S_W_ACH,
        S_DONE
    } state_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic tgt_low;
        logic div_done;
        logic search_last;
        logic out_busy;
    } status_t;

endpackage

/* sv/pcp_div.sv */
module pcp_div import pcp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic             long_mode,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    logic [NUM_W-1:0]     num_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [NUM_W-1:0]     quot_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DEN_W:0]       trial;
    logic [DEN_W:0]       diff;
    logic                 ge;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= long_mode ? DIV_CNT_W'(NUM_W - 1) : DIV_CNT_W'(DEN_W - 1);
                num_reg  <= long_mode ? num : {num[DEN_W-1:0], {(NUM_W-DEN_W){1'b0}}};
                den_reg  <= den;
                rem_reg  <= '0;
                quot_reg <= '0;
            end else if (busy_reg) begin
                rem_reg  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                quot_reg <= {quot_reg[NUM_W-2:0], ge};
                num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* sv/pcp_ctrl.sv */
module pcp_ctrl import pcp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DOUBLE;
                end
            end
            S_DOUBLE: begin
                if (status.tgt_low) begin
                    cmd.op = OP_DOUBLE;
                end else begin
                    state_next = S_DIV_CEIL;
                end
            end
            S_DIV_CEIL: begin
                cmd.op     = OP_DIV_CEIL;
                state_next = S_W_CEIL;
            end
            S_W_CEIL: begin
                if (status.div_done) begin
                    cmd.op     = OP_VCO;
                    state_next = S_DIV_RATIO;
                end
            end
            S_DIV_RATIO: begin
                cmd.op     = OP_DIV_RATIO;
                state_next = S_W_RATIO;
            end
            S_W_RATIO: begin
                if (status.div_done) begin
                    cmd.op     = OP_FB;
                    state_next = S_DIV_POST;
                end
            end
            S_DIV_POST: begin
                cmd.op     = OP_DIV_POST;
                state_next = S_W_POST;
            end
            S_W_POST: begin
                if (status.div_done) begin
                    cmd.op     = OP_CMP;
                    state_next = status.search_last ? S_MUL_LO : S_DIV_POST;
                end
            end
            S_MUL_LO: begin
                cmd.op     = OP_MUL_LO;
                state_next = S_MUL_HI;
            end
            S_MUL_HI: begin
                cmd.op     = OP_MUL_HI;
                state_next = S_DIV_PLL;
            end
            S_DIV_PLL: begin
                cmd.op     = OP_DIV_PLL;
                state_next = S_W_PLL;
            end
            S_W_PLL: begin
                if (status.div_done) begin
                    cmd.op     = OP_PLL;
                    state_next = S_DIV_Q;
                end
            end
            S_DIV_Q: begin
                cmd.op     = OP_DIV_Q;
                state_next = S_W_Q;
            end
            S_W_Q: begin
                if (status.div_done) begin
                    cmd.op     = OP_ODIV;
                    state_next = S_DIV_ACH;
                end
            end
            S_DIV_ACH: begin
                cmd.op     = OP_DIV_ACH;
                state_next = S_W_ACH;
            end
            S_W_ACH: begin
                if (status.div_done) begin
                    cmd.op     = OP_ACH;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!status.out_busy) begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* sv/pcp_datapath.sv */
module pcp_datapath import pcp_pkg::*; #(
    parameter int unsigned REF_HZ = PCP_REF_HZ
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam logic [REF_W-1:0] REF_VAL  = REF_W'(REF_HZ);
    localparam logic [NUM_W-1:0] REF_HALF = NUM_W'(REF_HZ / 2);
    localparam int PLO_W = REF_W + FRAC_W;
    localparam int PHI_W = REF_W + FB_FULL_W;

    logic [PIX_W-1:0]     pix_reg, tgt_reg;
    logic [VCO_W-1:0]     vco_reg;
    logic [FB_FULL_W-1:0] fbi_reg;
    logic [FRAC_W-1:0]    frac_reg;
    logic [PDIV_W-1:0]    d1_reg, d2_reg, best1_reg, best2_reg;
    logic [31:0]          best_err_reg;
    logic [PLO_W-1:0]     plo_reg;
    logic [PHI_W-1:0]     phi_reg;
    logic [31:0]          pll_reg;
    logic [ODIV_W-1:0]    odiv_reg;
    logic [ACH_W-1:0]     ach_reg;
    logic [OUT_DATA_W-1:0] out_reg;
    logic                 m_tvalid_reg;

    logic [31:0]      in_pix, pix_clamp;
    logic             div_start, div_long, div_done;
    logic [NUM_W-1:0] div_num, div_quot;
    logic [DEN_W-1:0] div_den;
    logic [5:0]       prod, best_prod;
    logic [31:0]      post_q, err;
    logic [NUM_W-1:0] ratio;
    logic [PHI_W:0]   vact;
    logic [PLO_W:0]   plo_round;

    assign in_pix    = s_tdata[31:0];
    assign pix_clamp = (in_pix < PIX_MIN_HZ) ? PIX_MIN_HZ :
                       (in_pix > PIX_MAX_HZ) ? PIX_MAX_HZ : in_pix;

    assign prod      = {3'd0, d1_reg} * {3'd0, d2_reg};
    assign best_prod = {3'd0, best1_reg} * {3'd0, best2_reg};
    assign post_q    = div_quot[31:0];
    assign err       = (post_q > {4'd0, tgt_reg}) ? post_q - {4'd0, tgt_reg}
                                                  : {4'd0, tgt_reg} - post_q;
    assign ratio     = div_quot + NUM_W'(128);
    assign plo_round = {1'b0, plo_reg} + (PLO_W+1)'(1 << 23);
    assign vact      = {1'b0, phi_reg} + (PHI_W+1)'(plo_round[PLO_W:24]);

    always_comb begin
        div_start = 1'b0;
        div_long  = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (cmd.op)
            OP_DIV_CEIL: begin
                div_start = 1'b1;
                div_num   = NUM_W'(VCO_MIN_HZ + {4'd0, tgt_reg} - 32'd1);
                div_den   = DEN_W'(tgt_reg);
            end
            OP_DIV_RATIO: begin
                div_start = 1'b1;
                div_long  = 1'b1;
                div_num   = {1'b0, vco_reg, 32'd0} + REF_HALF;
                div_den   = DEN_W'(REF_VAL);
            end
            OP_DIV_POST: begin
                div_start = 1'b1;
                div_num   = NUM_W'(vco_reg);
                div_den   = DEN_W'(prod);
            end
            OP_DIV_PLL: begin
                div_start = 1'b1;
                div_num   = NUM_W'(vact[31:0]);
                div_den   = DEN_W'(best_prod);
            end
            OP_DIV_Q: begin
                div_start = 1'b1;
                div_num   = NUM_W'(pll_reg + {5'd0, pix_reg[PIX_W-1:1]});
                div_den   = DEN_W'(pix_reg);
            end
            OP_DIV_ACH: begin
                div_start = 1'b1;
                div_num   = NUM_W'(pll_reg);
                div_den   = DEN_W'(odiv_reg);
            end
            default: ;
        endcase
    end

    pcp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .long_mode (div_long),
        .num       (div_num),
        .den       (div_den),
        .done      (div_done),
        .quot      (div_quot)
    );

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                pix_reg <= pix_clamp[PIX_W-1:0];
                tgt_reg <= pix_clamp[PIX_W-1:0];
            end
            OP_DOUBLE: tgt_reg <= {tgt_reg[PIX_W-2:0], 1'b0};
            OP_VCO:    vco_reg <= VCO_W'({tgt_reg, 1'b0} * div_quot[2:0]);
            OP_FB: begin
                fbi_reg      <= ratio[32 +: FB_FULL_W];
                frac_reg     <= ratio[31:8];
                d1_reg       <= 3'd1;
                d2_reg       <= 3'd1;
                best1_reg    <= POST_MAX;
                best2_reg    <= POST_MAX;
                best_err_reg <= '1;
            end
            OP_CMP: begin
                if (err < best_err_reg || (err == best_err_reg && prod < best_prod)) begin
                    best_err_reg <= err;
                    best1_reg    <= d1_reg;
                    best2_reg    <= d2_reg;
                end
                if (d2_reg == d1_reg) begin
                    d1_reg <= d1_reg + 3'd1;
                    d2_reg <= 3'd1;
                end else begin
                    d2_reg <= d2_reg + 3'd1;
                end
            end
            OP_MUL_LO: plo_reg <= PLO_W'(REF_VAL) * PLO_W'(frac_reg);
            OP_MUL_HI: phi_reg <= PHI_W'(REF_VAL) * PHI_W'(fbi_reg);
            OP_PLL:    pll_reg <= div_quot[31:0];
            OP_ODIV: begin
                if (div_quot == '0) begin
                    odiv_reg <= 8'd1;
                end else if (div_quot > NUM_W'(DIV_MAX)) begin
                    odiv_reg <= DIV_MAX;
                end else begin
                    odiv_reg <= div_quot[ODIV_W-1:0];
                end
            end
            OP_ACH: ach_reg <= div_quot[ACH_W-1:0];
            OP_OUT: begin
                out_reg <= {5'd0, ach_reg, odiv_reg, best2_reg, best1_reg,
                            (frac_reg == '0), frac_reg, fbi_reg[FB_INT_W-1:0],
                            vco_reg, tgt_reg, pix_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.op == OP_OUT) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign status.tgt_low     = tgt_reg < TGT_MIN_HZ;
    assign status.div_done    = div_done;
    assign status.search_last = (d1_reg == POST_MAX) && (d2_reg == POST_MAX);
    assign status.out_busy    = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

endmodule

/* sv/pixel_clock_pll_planner.sv */
// Pixel clock PLL planner.
// The shared serial divider (one quotient bit per cycle) sets the run time of a beat: one 64-bit
// division and thirty-two 32-bit divisions; up to seven doublings of a low request add to it.
// One beat in flight; the next beat is taken while a result waits.
// Reset: aresetn (sync, active low) clears the controller, the divider and output valid.
module pixel_clock_pll_planner import pcp_pkg::*; #(
    parameter int unsigned REF_HZ = PCP_REF_HZ
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] requested_pixel_hz
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [27:0] clamped_pixel_hz, [55:28] pll_target_hz, [86:56] vco_target_hz,
    // [92:87] feedback_int, [116:93] feedback_frac, [117] integer_mode,
    // [120:118] post_div_first, [123:121] post_div_second, [131:124] output_div,
    // [162:132] achieved_pixel_hz, [167:163] zero
    output logic [OUT_DATA_W-1:0] m_tdata
);

    cmd_t    cmd;
    status_t status;

    pcp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pcp_datapath #(
        .REF_HZ (REF_HZ)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* tb/pixel_clock_pll_planner_checker.sv */
`timescale 1ns / 1ps

module pixel_clock_pll_planner_checker import pcp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    fail_count,
    output int                    plans_pending
);

    typedef struct packed {
        logic [ACH_W-1:0]  achieved;
        logic [ODIV_W-1:0] odiv;
        logic [PDIV_W-1:0] pd2;
        logic [PDIV_W-1:0] pd1;
        logic              int_mode;
        logic [FRAC_W-1:0] frac;
        logic [FB_INT_W-1:0] fb_int;
        logic [VCO_W-1:0]  vco;
        logic [PIX_W-1:0]  tgt;
        logic [PIX_W-1:0]  pix;
    } pll_plan_t;

    pll_plan_t expected_plans[$];

    function automatic logic [31:0] hz_distance(logic [31:0] a, logic [31:0] b);
        return a > b ? a - b : b - a;
    endfunction

    function automatic pll_plan_t plan_pll(logic [31:0] req);
        pll_plan_t p;
        logic [31:0] pix, tgt, vco, fb_int, fb_frac, err, best_err, b1, b2, q;
        logic [63:0] ratio, vco_act, pll_out;
        pix = req;
        if (pix < PIX_MIN_HZ) pix = PIX_MIN_HZ;
        if (pix > PIX_MAX_HZ) pix = PIX_MAX_HZ;
        tgt = pix;
        while (tgt < 32'd100000000) tgt = tgt * 2;
        vco = tgt * 2 * ((VCO_MIN_HZ + tgt - 1) / tgt);
        ratio = (({32'd0, vco} << 32) + 64'(PCP_REF_HZ / 2)) / 64'(PCP_REF_HZ);
        ratio = ratio + (64'd1 << 7);
        fb_int = ratio[63:32];
        fb_frac = {8'd0, ratio[31:8]};
        b1 = 7; b2 = 7; best_err = 32'hffffffff;
        for (int d1 = 1; d1 <= 7; d1++) begin
            for (int d2 = 1; d2 <= d1; d2++) begin
                err = hz_distance(vco / (d1 * d2), tgt);
                if (err < best_err || (err == best_err && d1 * d2 < b1 * b2)) begin
                    best_err = err;
                    b1 = d1;
                    b2 = d2;
                end
            end
        end
        vco_act = (64'(PCP_REF_HZ) * (({32'd0, fb_int} << 24) + fb_frac)
                   + (64'd1 << 23)) >> 24;
        pll_out = vco_act / 64'(b1 * b2);
        q = 32'((pll_out + 64'(pix / 2)) / 64'(pix));
        if ((pll_out + 64'(pix / 2)) / 64'(pix) > 64'd255) q = 255;
        if (q == 0) q = 1;
        p.pix = pix[PIX_W-1:0];
        p.tgt = tgt[PIX_W-1:0];
        p.vco = vco[VCO_W-1:0];
        p.fb_int = fb_int[FB_INT_W-1:0];
        p.frac = fb_frac[FRAC_W-1:0];
        p.int_mode = (fb_frac == 0);
        p.pd1 = b1[2:0];
        p.pd2 = b2[2:0];
        p.odiv = q[7:0];
        p.achieved = 31'(pll_out / 64'(q));
        return p;
    endfunction

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        plans_pending = 0;
    end

    always @(posedge aclk) begin
        pll_plan_t e, a;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_plans.push_back(plan_pll(s_tdata));
            if (m_tvalid && m_tready) begin
                a = m_tdata[$bits(pll_plan_t)-1:0];
                if (expected_plans.size() == 0) begin
                    $error("result beat with no request pending");
                    fail_count++;
                end else begin
                    e = expected_plans.pop_front();
                    check_field("clamped_pixel_hz", e.pix, a.pix);
                    check_field("pll_target_hz", e.tgt, a.tgt);
                    check_field("vco_target_hz", e.vco, a.vco);
                    check_field("feedback_int", e.fb_int, a.fb_int);
                    check_field("feedback_frac", e.frac, a.frac);
                    check_field("integer_mode", e.int_mode, a.int_mode);
                    check_field("post_div_first", e.pd1, a.pd1);
                    check_field("post_div_second", e.pd2, a.pd2);
                    check_field("output_div", e.odiv, a.odiv);
                    check_field("achieved_pixel_hz", e.achieved, a.achieved);
                end
            end
        end
        plans_pending = expected_plans.size();
    end

endmodule

/* tb/pixel_clock_pll_planner_test.sv */
`timescale 1ns / 1ps

module pixel_clock_pll_planner_test import pcp_pkg::*;;

    localparam int RANDOM_REQS = 480;
    localparam longint CYCLE_LIMIT = 64'd4000000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    int                    fail_count;
    int                    plans_pending;
    longint                cycles = 0;
    logic                  long_hold = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    pixel_clock_pll_planner dut (.*);

    pixel_clock_pll_planner_checker checker_i (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("pixel_clock_pll_planner regression: fail");
            $finish;
        end
    end

    // receiver: stalls in its own pattern; long_hold forces a long stretch off
    initial begin
        int mode;
        mode = 0;
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 2);
            if (long_hold) m_tready <= 1'b0;
            else if (mode == 0) m_tready <= 1'b1;
            else if (mode == 1) m_tready <= ($urandom_range(0, 3) != 0);
            else m_tready <= ($urandom_range(0, 9) == 0);
        end
    end

    task automatic send_request(logic [31:0] hz);
        s_tvalid <= 1'b1;
        s_tdata <= hz;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] random_request();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1000000);
            2: return $urandom_range(200000000, 32'hffffffff);
            default: return $urandom_range(1000000, 200000000);
        endcase
    endfunction

    initial begin
        logic [31:0] directed[$];
        int burst;
        directed = '{32'd0, 32'd1, 32'd999999, 32'd1000000, 32'd1000001, 32'd25175000,
                     32'd49999999, 32'd50000000, 32'd74250000, 32'd99999999,
                     32'd100000000, 32'd100000001, 32'd148500000, 32'd166666667,
                     32'd199999999, 32'd200000000, 32'd200000001, 32'hffffffff,
                     32'h80000000, 32'h55555555, 32'haaaaaaaa, 32'd250000000};
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (directed[i]) send_request(directed[i]);
        s_tvalid <= 1'b0;

        // hold the receiver off while requests keep coming
        long_hold <= 1'b1;
        fork
            begin
                repeat (6000) @(negedge aclk);
                long_hold <= 1'b0;
            end
            repeat (4) send_request(random_request());
        join
        s_tvalid <= 1'b0;

        burst = 0;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n == RANDOM_REQS / 2) begin
                s_tvalid <= 1'b0;
                while (plans_pending != 0) @(negedge aclk);
            end
            if (burst == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(0, 1500)) @(negedge aclk);
                burst = $urandom_range(1, 8);
            end
            send_request(random_request());
            burst--;
        end
        s_tvalid <= 1'b0;

        while (plans_pending != 0) @(negedge aclk);
        repeat (1300) @(negedge aclk);
        if (fail_count == 0)
            $display("pixel_clock_pll_planner regression: pass");
        else
            $display("pixel_clock_pll_planner regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
sv/pcp_pkg.sv
sv/pcp_div.sv
sv/pcp_ctrl.sv
sv/pcp_datapath.sv
sv/pixel_clock_pll_planner.sv
tb/pixel_clock_pll_planner_checker.sv
tb/pixel_clock_pll_planner_test.sv
